/* rtl/core/kmcs_pkg.sv */
// Shared types and constants for the keyed minimum-cost select core.
// Used by kmcs_table, the top level and the port checker; no dependencies.
package kmcs_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(TABLE_DEPTH - 1);

    localparam logic [7:0]  END_MARK  = 8'hff;
    localparam logic [7:0]  USED_COST = 8'hfe;
    localparam logic [13:0] NONE_X    = 14'd9999;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [5:0] entry_index;
        logic [7:0] entry_x;
        logic [7:0] entry_y;
        logic [7:0] entry_group;
        logic [7:0] entry_cost;
        logic [7:0] match_key;
    } t_in_beat;

    typedef struct packed {
        logic        found;
        logic [13:0] pick_x;
        logic [7:0]  pick_y;
        logic [5:0]  pick_index;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] group;
        logic [7:0] cost;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_tbl_wr;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_tbl_rd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_MARK
    } t_state;

    localparam t_entry RESET_ENTRY = '{x: END_MARK, y: 8'd0, group: 8'd0, cost: USED_COST};
    localparam t_out_beat NONE_RESULT =
        '{found: 1'b0, pick_x: NONE_X, pick_y: 8'd0, pick_index: 6'd0};

endpackage

/* rtl/core/kmcs_table.sv */
// Entry table: one write port, one registered read port, per-entry valid bits.
// An entry never written reads as the reset entry. Depends on kmcs_pkg.
module kmcs_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kmcs_pkg::t_tbl_wr i_wr,
    input  kmcs_pkg::t_tbl_rd i_rd,
    output kmcs_pkg::t_entry  o_rd_data
);

    kmcs_pkg::t_entry mem [kmcs_pkg::TABLE_DEPTH];
    logic [kmcs_pkg::TABLE_DEPTH-1:0] r_valid;
    kmcs_pkg::t_entry r_rd_data;
    logic r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_vld <= r_valid[i_rd.addr];
            end
        end
    end

    // untouched entries show the reset contents
    assign o_rd_data = r_rd_vld ? r_rd_data : kmcs_pkg::RESET_ENTRY;

endmodule

/* rtl/core/keyed_min_cost_select_consume_core.sv */
// Keyed minimum-cost select core: top level with the walk sequencer.
// Depends on kmcs_pkg and kmcs_table.
//
// A write beat (opcode 0) is taken without leaving idle: busy stays low, the entry is
// stored, and a fixed "nothing found" result strobes out on the next cycle. A
// select beat (opcode 1) raises busy and walks the table from position 0, one
// entry per cycle through the table's single registered read port, stopping at
// the first entry whose x is 255 or after the last position. With a match,
// the mark state then writes the chosen entry back with cost 254. A select
// thus keeps busy high while it walks its 1 to 64 entries and, when an entry
// is chosen, while it marks it; its result strobes in the same cycle busy
// falls. Every result is on o_res for exactly one cycle with o_strobe high;
// the receiver cannot stall, so sample it then.
// A new beat may be started in the same cycle a result is shown. No clearing
// pass is needed after reset: the table carries a valid bit per entry.
module keyed_min_cost_select_consume_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  kmcs_pkg::t_in_beat  i_in,
    output logic                busy,
    output logic                o_strobe,
    output kmcs_pkg::t_out_beat o_res
);

    kmcs_pkg::t_state r_state, n_state;
    logic [kmcs_pkg::IDX_W-1:0] r_cur, n_cur;
    logic [7:0] r_limit, n_limit;
    logic       r_hit, n_hit;
    logic [kmcs_pkg::IDX_W-1:0] r_best_idx, n_best_idx;
    logic [7:0] r_best_x, n_best_x;
    logic [7:0] r_best_y, n_best_y;
    logic [7:0] r_key, n_key;
    kmcs_pkg::t_out_beat r_res, n_res;
    logic r_strobe, n_strobe;

    kmcs_pkg::t_tbl_wr tbl_wr;
    kmcs_pkg::t_tbl_rd tbl_rd;
    kmcs_pkg::t_entry  rd_ent;

    logic walk_end;
    logic walk_done;
    logic take;

    kmcs_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd      (tbl_rd),
        .o_rd_data (rd_ent)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kmcs_pkg::ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_limit    <= n_limit;
        r_hit      <= n_hit;
        r_best_idx <= n_best_idx;
        r_best_x   <= n_best_x;
        r_best_y   <= n_best_y;
        r_key      <= n_key;
        r_res      <= n_res;
    end

    // rd_ent holds the entry at r_cur during the walk
    assign walk_end  = (rd_ent.x == kmcs_pkg::END_MARK);
    assign take      = !walk_end && (rd_ent.cost < r_limit) && (rd_ent.group == r_key);
    assign walk_done = walk_end || (r_cur == kmcs_pkg::LAST_POS);

    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_limit    = r_limit;
        n_hit      = r_hit;
        n_best_idx = r_best_idx;
        n_best_x   = r_best_x;
        n_best_y   = r_best_y;
        n_key      = r_key;
        n_res      = r_res;
        n_strobe   = 1'b0;
        tbl_wr     = '0;
        tbl_rd     = '0;

        unique case (r_state)
            kmcs_pkg::ST_IDLE: begin
                if (start) begin
                    if (i_in.opcode == kmcs_pkg::OP_WRITE) begin
                        // drop writes beyond the table
                        if (32'(i_in.entry_index) < 32'(kmcs_pkg::TABLE_DEPTH)) begin
                            tbl_wr.en         = 1'b1;
                            tbl_wr.addr       = kmcs_pkg::IDX_W'(i_in.entry_index);
                            tbl_wr.data.x     = i_in.entry_x;
                            tbl_wr.data.y     = i_in.entry_y;
                            tbl_wr.data.group = i_in.entry_group;
                            tbl_wr.data.cost  = i_in.entry_cost;
                        end
                        n_res    = kmcs_pkg::NONE_RESULT;
                        n_strobe = 1'b1;
                    end else begin
                        // issue the read of position 0 and arm the search
                        tbl_rd.en   = 1'b1;
                        tbl_rd.addr = '0;
                        n_cur       = '0;
                        n_limit     = kmcs_pkg::USED_COST;
                        n_hit       = 1'b0;
                        n_key       = i_in.match_key;
                        n_state     = kmcs_pkg::ST_WALK;
                    end
                end
            end

            kmcs_pkg::ST_WALK: begin
                // strict less-than keeps the earliest entry on equal cost
                if (take) begin
                    n_limit    = rd_ent.cost;
                    n_hit      = 1'b1;
                    n_best_idx = r_cur;
                    n_best_x   = rd_ent.x;
                    n_best_y   = rd_ent.y;
                end
                if (walk_done) begin
                    if (n_hit) begin
                        n_state = kmcs_pkg::ST_MARK;
                    end else begin
                        n_res    = kmcs_pkg::NONE_RESULT;
                        n_strobe = 1'b1;
                        n_state  = kmcs_pkg::ST_IDLE;
                    end
                end else begin
                    // advance: fetch the next position while this one is judged
                    tbl_rd.en   = 1'b1;
                    tbl_rd.addr = r_cur + kmcs_pkg::IDX_W'(1);
                    n_cur       = r_cur + kmcs_pkg::IDX_W'(1);
                end
            end

            kmcs_pkg::ST_MARK: begin
                // consume the chosen entry: rewrite it with the used cost
                tbl_wr.en         = 1'b1;
                tbl_wr.addr       = r_best_idx;
                tbl_wr.data.x     = r_best_x;
                tbl_wr.data.y     = r_best_y;
                tbl_wr.data.group = r_key;
                tbl_wr.data.cost  = kmcs_pkg::USED_COST;
                n_res.found       = 1'b1;
                n_res.pick_x      = 14'(r_best_x);
                n_res.pick_y      = r_best_y;
                n_res.pick_index  = 6'(r_best_idx);
                n_strobe          = 1'b1;
                n_state           = kmcs_pkg::ST_IDLE;
            end

            default: begin
                n_state = kmcs_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != kmcs_pkg::ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

/* rtl/core/kmcs_checker.sv */
// Port-level checker for the keyed minimum-cost select core, bound to the top.
// Depends on kmcs_pkg and keyed_min_cost_select_consume_core.
module kmcs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input kmcs_pkg::t_in_beat  i_in,
    input logic                busy,
    input logic                o_strobe,
    input kmcs_pkg::t_out_beat o_res
);

    // a write beat answers on the next cycle with the empty result
    a_write_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_in.opcode == kmcs_pkg::OP_WRITE)
        |=> o_strobe && !o_res.found && (o_res.pick_x == kmcs_pkg::NONE_X))
        else $error("write beat without its result");

    // a select beat holds the block busy
    a_select_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_in.opcode == kmcs_pkg::OP_SELECT) |=> busy && !o_strobe)
        else $error("select beat did not raise busy");

    // an empty result carries the fixed fill values
    a_none_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.found
        |-> (o_res.pick_x == kmcs_pkg::NONE_X) && (o_res.pick_y == 8'd0)
            && (o_res.pick_index == 6'd0))
        else $error("empty result with stray fields");

    // a terminator can never be chosen
    a_pick_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.found |-> (o_res.pick_x < 14'(kmcs_pkg::END_MARK)))
        else $error("chosen entry carries the end mark");

    // reset leaves the block idle and quiet
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !busy && !o_strobe)
        else $error("block not idle after reset");

endmodule

bind keyed_min_cost_select_consume_core kmcs_checker u_kmcs_checker (.*);

/* test/tb_keyed_min_cost_select_consume_core.sv */
// Testbench for keyed_min_cost_select_consume_core: directed and random beats,
// with an in-bench table model that predicts every result. Depends on kmcs_pkg and the core.
module tb_keyed_min_cost_select_consume_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT_NS = 3_000_000;
    localparam int DRAIN_LIMIT  = 200;   // cycles
    localparam int TAIL_CYCLES  = 70;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    kmcs_pkg::t_in_beat  i_in;
    logic                busy;
    logic                o_strobe;
    kmcs_pkg::t_out_beat o_res;

    keyed_min_cost_select_consume_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_in    (i_in),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the entry table, updated in the order beats are accepted.
    logic [7:0] tbl_x    [kmcs_pkg::TABLE_DEPTH];
    logic [7:0] tbl_y    [kmcs_pkg::TABLE_DEPTH];
    logic [7:0] tbl_grp  [kmcs_pkg::TABLE_DEPTH];
    logic [7:0] tbl_cost [kmcs_pkg::TABLE_DEPTH];

    kmcs_pkg::t_out_beat pending_picks[$];   // predicted results, oldest first
    int        mismatch_cnt = 0;
    int        beats_sent   = 0;
    int        sender_idle_pct = 0;

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------
    task automatic clear_table_model();
        for (int i = 0; i < kmcs_pkg::TABLE_DEPTH; i++) begin
            tbl_x[i]    = kmcs_pkg::END_MARK;
            tbl_y[i]    = 8'd0;
            tbl_grp[i]  = 8'd0;
            tbl_cost[i] = kmcs_pkg::USED_COST;
        end
    endtask

    // Store a write beat, or walk the table for a select and consume the
    // cheapest matching entry. Every beat yields exactly one result.
    function automatic kmcs_pkg::t_out_beat predict_pick(input kmcs_pkg::t_in_beat b);
        kmcs_pkg::t_out_beat r;
        logic [7:0] low_cost;
        int         best;
        bit         hit;
        r = kmcs_pkg::NONE_RESULT;
        if (b.opcode == kmcs_pkg::OP_WRITE) begin
            if (int'(b.entry_index) < kmcs_pkg::TABLE_DEPTH) begin
                tbl_x[b.entry_index]    = b.entry_x;
                tbl_y[b.entry_index]    = b.entry_y;
                tbl_grp[b.entry_index]  = b.entry_group;
                tbl_cost[b.entry_index] = b.entry_cost;
            end
            return r;
        end
        low_cost = kmcs_pkg::USED_COST;
        best     = 0;
        hit      = 1'b0;
        for (int i = 0; i < kmcs_pkg::TABLE_DEPTH; i++) begin
            if (tbl_x[i] == kmcs_pkg::END_MARK)
                break;
            // strict less-than keeps the earliest entry on equal costs
            if (tbl_cost[i] < low_cost && tbl_grp[i] == b.match_key) begin
                low_cost = tbl_cost[i];
                best     = i;
                hit      = 1'b1;
            end
        end
        if (hit) begin
            r.found      = 1'b1;
            r.pick_x     = 14'(tbl_x[best]);
            r.pick_y     = tbl_y[best];
            r.pick_index = 6'(best);
            tbl_cost[best] = kmcs_pkg::USED_COST;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Beat builders; fields a beat does not use carry random values
    // ------------------------------------------------------------------
    function automatic kmcs_pkg::t_in_beat write_beat(input logic [5:0] idx,
                                                      input logic [7:0] x,
                                                      input logic [7:0] y,
                                                      input logic [7:0] grp,
                                                      input logic [7:0] cost);
        kmcs_pkg::t_in_beat b;
        b.opcode      = kmcs_pkg::OP_WRITE;
        b.entry_index = idx;
        b.entry_x     = x;
        b.entry_y     = y;
        b.entry_group = grp;
        b.entry_cost  = cost;
        b.match_key   = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic kmcs_pkg::t_in_beat select_beat(input logic [7:0] key);
        kmcs_pkg::t_in_beat b;
        b.opcode      = kmcs_pkg::OP_SELECT;
        b.entry_index = 6'($urandom_range(63));
        b.entry_x     = 8'($urandom_range(255));
        b.entry_y     = 8'($urandom_range(255));
        b.entry_group = 8'($urandom_range(255));
        b.entry_cost  = 8'($urandom_range(255));
        b.match_key   = key;
        return b;
    endfunction

    function automatic kmcs_pkg::t_in_beat random_beat();
        kmcs_pkg::t_in_beat b;
        b = write_beat(6'($urandom_range(63)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
        b.opcode = $urandom_range(1) ? kmcs_pkg::OP_SELECT : kmcs_pkg::OP_WRITE;
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Sender: called at a rising edge, returns at the edge at which the block
    // takes the beat, that is the first edge at which it is idle
    task automatic send_beat(input kmcs_pkg::t_in_beat b);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            // drop start and show junk on the data bus while idle
            start <= 1'b0;
            i_in  <= random_beat();
            repeat (gap) @(posedge i_clk);
        end
        i_in  <= b;
        start <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_picks.push_back(predict_pick(b));
        beats_sent++;
    endtask

    // Hold off the sender until every predicted result has been seen or DRAIN_LIMIT runs out.
    task automatic drain_results();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_picks.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_picks.size() != 0) begin
            $display("%0t: %0d result(s) never arrived, oldest expected %p",
                     $realtime, pending_picks.size(), pending_picks[0]);
            mismatch_cnt += pending_picks.size();
            pending_picks.delete();
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic cmp_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $realtime, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        kmcs_pkg::t_out_beat want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_picks.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p",
                         $realtime, o_res);
                mismatch_cnt++;
            end else begin
                want = pending_picks.pop_front();
                if ($isunknown(o_res)) begin
                    $display("%0t: unknown bits in result, expected %p, actual %p",
                             $realtime, want, o_res);
                    mismatch_cnt++;
                end else begin
                    cmp_field("found",      want.found,      o_res.found);
                    cmp_field("pick_x",     want.pick_x,     o_res.pick_x);
                    cmp_field("pick_y",     want.pick_y,     o_res.pick_y);
                    cmp_field("pick_index", want.pick_index, o_res.pick_index);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes of every field, both opcodes, used costs, ties, a terminator
    // hiding later entries and a select on an untouched table.
    task automatic test_directed();
        send_beat(select_beat(8'h00));                          // empty table
        send_beat(write_beat(6'd0,  8'd0,   8'd255, 8'hff, 8'd0));
        send_beat(write_beat(6'd1,  8'd254, 8'd0,   8'hff, 8'd253));
        send_beat(write_beat(6'd2,  8'd7,   8'd8,   8'hff, kmcs_pkg::USED_COST));
        send_beat(write_beat(6'd3,  8'd9,   8'd9,   8'hff, 8'd255));
        send_beat(write_beat(6'd4,  8'd10,  8'd11,  8'h00, 8'd5));
        send_beat(write_beat(6'd5,  8'd12,  8'd13,  8'h00, 8'd5));   // tie
        send_beat(write_beat(6'd6,  kmcs_pkg::END_MARK, 8'd1, 8'h00, 8'd0)); // list end
        send_beat(write_beat(6'd7,  8'd1,   8'd1,   8'h00, 8'd0));   // hidden
        send_beat(write_beat(6'd63, 8'd3,   8'd4,   8'h00, 8'd1));   // hidden
        send_beat(select_beat(8'hff));
        send_beat(select_beat(8'hff));
        send_beat(select_beat(8'hff));                          // only costs 254 and 255 left
        send_beat(select_beat(8'h00));                          // earliest of tie
        send_beat(select_beat(8'h00));
        send_beat(select_beat(8'h00));                          // all consumed
        send_beat(select_beat(8'h5a));                          // no such key
        // reopen the first hidden entry by overwriting the terminator
        send_beat(write_beat(6'd6,  8'd2,   8'd2,   8'h55, 8'd100));
        send_beat(select_beat(8'h00));
        drain_results();
    endtask

    // Fill every position so the walk runs off the end of the table; the
    // cheapest entry sits at the last position.
    task automatic test_full_walk();
        for (int i = 0; i < kmcs_pkg::TABLE_DEPTH; i++)
            send_beat(write_beat(6'(i), 8'($urandom_range(254)), 8'($urandom_range(255)),
                                 8'h3c, 8'(kmcs_pkg::TABLE_DEPTH + 10 - i)));
        send_beat(select_beat(8'h3c));
        send_beat(select_beat(8'h3c));
        drain_results();
    endtask

    // Mostly well-formed lists from position 0 followed by selects on a small
    // key pool; the rest is single random beats.
    task automatic test_random_lists(input int n_beats);
        logic [7:0] key_pool [3];
        int         stop_at;
        int         len;
        int         n_sel;
        logic [7:0] x;
        logic [7:0] cost;
        logic [7:0] grp;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            if ($urandom_range(99) < 70) begin
                foreach (key_pool[k])
                    key_pool[k] = 8'($urandom_range(255));
                len = ($urandom_range(15) == 0) ? kmcs_pkg::TABLE_DEPTH
                                                : $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    // a rare early terminator breaks the list
                    x = ($urandom_range(39) == 0) ? kmcs_pkg::END_MARK
                                                  : 8'($urandom_range(254));
                    case ($urandom_range(9))
                        0:       cost = 8'($urandom_range(254, 255));
                        1:       cost = 8'($urandom_range(255));
                        default: cost = 8'($urandom_range(31));
                    endcase
                    grp = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                   : key_pool[$urandom_range(2)];
                    send_beat(write_beat(6'(i), x, 8'($urandom_range(255)), grp, cost));
                end
                // leaving the old terminator position alone lets stale
                // entries from earlier lists join the walk
                if (len < kmcs_pkg::TABLE_DEPTH && $urandom_range(3) != 0)
                    send_beat(write_beat(6'(len), kmcs_pkg::END_MARK,
                                         8'($urandom_range(255)),
                                         8'($urandom_range(255)), 8'($urandom_range(255))));
                n_sel = $urandom_range(1, len + 2);
                for (int s = 0; s < n_sel; s++)
                    send_beat(select_beat(($urandom_range(5) == 0)
                                          ? 8'($urandom_range(255))
                                          : key_pool[$urandom_range(2)]));
                if ($urandom_range(19) == 0)
                    drain_results();
            end else begin
                send_beat(random_beat());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_in    <= '0;
        clear_table_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_walk();

        sender_idle_pct = 26;
        test_random_lists(650);
        drain_results();
        sender_idle_pct = 55;
        test_random_lists(650);
        drain_results();
        sender_idle_pct = 0;
        test_random_lists(650);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("%0t: run limit reached", $realtime);
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* keyed_min_cost_select_consume_core.f */
rtl/core/kmcs_pkg.sv
rtl/core/kmcs_table.sv
rtl/core/keyed_min_cost_select_consume_core.sv
rtl/core/kmcs_checker.sv
test/tb_keyed_min_cost_select_consume_core.sv
